FILE: hw/rtl/button_speed_ramp_controller_assert.svh
// assertion macros used by the checker file
`ifndef BUTTON_SPEED_RAMP_CONTROLLER_ASSERT_SVH
`define BUTTON_SPEED_RAMP_CONTROLLER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define BSRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define BSRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bsrc_pkg.sv
`timescale 1ns / 1ps

package bsrc_pkg;

    // configuration register width and reset values
    localparam int unsigned CFG_W             = 10;
    localparam logic [CFG_W-1:0] SPEED_MAX_RST   = 10'd400;
    localparam logic [CFG_W-1:0] STEP_COARSE_RST = 10'd10;
    localparam logic [CFG_W-1:0] STEP_FINE_RST   = 10'd1;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SPEED_MAX   = 2'd0,
        REG_STEP_COARSE = 2'd1,
        REG_STEP_FINE   = 2'd2
    } cfg_reg_t;

    // operation codes carried on tuser
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // button bit positions
    localparam int unsigned BTN_W      = 5;
    localparam int unsigned BTN_RIGHT  = 0;
    localparam int unsigned BTN_LEFT   = 1;
    localparam int unsigned BTN_UP     = 2;
    localparam int unsigned BTN_DOWN   = 3;
    localparam int unsigned BTN_SELECT = 4;

    // input request packing
    localparam int unsigned IN_W       = 8;
    localparam int unsigned IN_FAULT_B = 5;

endpackage

FILE: hw/rtl/button_speed_ramp_controller.sv
`timescale 1ns / 1ps

// Button driven signed speed ramp. A request with tuser = 0 is a button event that changes
// the target speed (coarse up, coarse down, fine away from zero, fine toward zero, by
// priority) or toggles the run flag on select; the target is clamped to plus or minus
// speed_max, and never beyond the largest positive SPEED_WIDTH value. A request with
// tuser = 1 is a ramp tick that moves the speed one unit toward the target (toward zero
// when stopped). A driver fault seen on a speed step latches until reset and freezes
// everything. Every request gives exactly one result. Throughput is one request per
// cycle while m_axis_tready keeps up; a request passes from the input register to the
// result register through a single add, clamp and compare for the state update.
// Configuration writes take effect on the next edge.
module button_speed_ramp_controller
    import bsrc_pkg::*;
#(
    parameter int SPEED_WIDTH = 11
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_addr,
    input  logic [CFG_W-1:0]                  cfg_wdata,
    // input requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_W-1:0]                   s_axis_tdata,  // buttons[4:0], driver_fault
    input  logic                              s_axis_tuser,  // op
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // speed, target_speed, driver_on, running, at_target, faulted
    output logic [((2*SPEED_WIDTH+4+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_W  = ((2*SPEED_WIDTH+4+7)/8)*8;
    localparam int WIDE   = ((SPEED_WIDTH > CFG_W) ? SPEED_WIDTH : CFG_W) + 2;
    localparam int TOP_I  = (1 << (SPEED_WIDTH-1)) - 1;
    localparam logic signed [WIDE-1:0] TOP = WIDE'(TOP_I);
    localparam int B_DRV  = 2*SPEED_WIDTH;
    localparam int B_RUN  = 2*SPEED_WIDTH + 1;
    localparam int B_AT   = 2*SPEED_WIDTH + 2;
    localparam int B_FLT  = 2*SPEED_WIDTH + 3;

    // configuration registers
    logic [CFG_W-1:0] speed_max_reg;
    logic [CFG_W-1:0] step_coarse_reg;
    logic [CFG_W-1:0] step_fine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_max_reg   <= SPEED_MAX_RST;
            step_coarse_reg <= STEP_COARSE_RST;
            step_fine_reg   <= STEP_FINE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SPEED_MAX:   speed_max_reg   <= cfg_wdata;
                REG_STEP_COARSE: step_coarse_reg <= cfg_wdata;
                REG_STEP_FINE:   step_fine_reg   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // input register
    logic             in_valid_reg;
    logic             in_op_reg;
    logic [BTN_W-1:0] in_btn_reg;
    logic             in_fault_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg    <= s_axis_tuser;
            in_btn_reg   <= s_axis_tdata[BTN_W-1:0];
            in_fault_reg <= s_axis_tdata[IN_FAULT_B];
        end
    end

    // ramp state
    logic signed [SPEED_WIDTH-1:0] target_reg, target_next;
    logic signed [SPEED_WIDTH-1:0] current_reg, current_next;
    logic                          run_reg, run_next;
    logic                          enable_reg, enable_next;
    logic                          fault_reg, fault_next;

    // event arithmetic, wide enough to hold an unclamped sum
    logic signed [WIDE-1:0] t_ext;
    logic signed [WIDE-1:0] coarse_ext;
    logic signed [WIDE-1:0] fine_ext;
    logic signed [WIDE-1:0] lim;
    logic signed [WIDE-1:0] t_sum;
    logic signed [WIDE-1:0] t_clamped;
    logic signed [SPEED_WIDTH-1:0] goal;
    logic signed [SPEED_WIDTH-1:0] goal_next;
    logic                          at_target;

    always_comb
    begin
        t_ext      = WIDE'(target_reg);
        coarse_ext = $signed({{(WIDE-CFG_W){1'b0}}, step_coarse_reg});
        fine_ext   = $signed({{(WIDE-CFG_W){1'b0}}, step_fine_reg});
        lim        = $signed({{(WIDE-CFG_W){1'b0}}, speed_max_reg});
        if (lim > TOP)
            lim = TOP;

        target_next  = target_reg;
        current_next = current_reg;
        run_next     = run_reg;
        enable_next  = enable_reg;
        fault_next   = fault_reg;
        goal         = run_reg ? target_reg : '0;

        // button priority: right, left, up, down, select
        t_sum = t_ext;
        if (in_btn_reg[BTN_RIGHT])
            t_sum = t_ext + coarse_ext;
        else if (in_btn_reg[BTN_LEFT])
            t_sum = t_ext - coarse_ext;
        else if (in_btn_reg[BTN_UP])
        begin
            if (t_ext > 0)
                t_sum = t_ext + fine_ext;
            else if (t_ext < 0)
                t_sum = t_ext - fine_ext;
        end
        else if (in_btn_reg[BTN_DOWN])
        begin
            if (t_ext > 0)
                t_sum = t_ext - fine_ext;
            else if (t_ext < 0)
                t_sum = t_ext + fine_ext;
        end

        // clamp to the magnitude limit
        t_clamped = t_sum;
        if (t_sum > lim)
            t_clamped = lim;
        else if (t_sum < -lim)
            t_clamped = -lim;

        if (!fault_reg)
        begin
            if (in_op_reg == OP_EVENT)
            begin
                if (in_btn_reg != '0)
                begin
                    target_next = SPEED_WIDTH'(t_clamped);
                    if (in_btn_reg[BTN_W-1:0] == (BTN_W'(1) << BTN_SELECT))
                        run_next = !run_reg;
                end
            end
            else
            begin
                // one unit step toward the goal, fault sampled on a step
                if (current_reg == '0 && run_reg && target_reg != '0)
                    enable_next = 1'b1;
                if (current_reg != goal)
                begin
                    current_next = (goal > current_reg) ? current_reg + 1'b1
                                                        : current_reg - 1'b1;
                    if (in_fault_reg)
                    begin
                        fault_next  = 1'b1;
                        enable_next = 1'b0;
                    end
                end
                if (!fault_next && current_next == '0 && goal == '0)
                    enable_next = 1'b0;
            end
        end

        goal_next = run_next ? target_next : '0;
        at_target = (current_next == goal_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '0;
            current_reg <= '0;
            run_reg     <= 1'b0;
            enable_reg  <= 1'b0;
            fault_reg   <= 1'b0;
        end
        else if (advance)
        begin
            target_reg  <= target_next;
            current_reg <= current_next;
            run_reg     <= run_next;
            enable_reg  <= enable_next;
            fault_reg   <= fault_next;
        end
    end

    // result register
    logic [OUT_W-1:0] out_data_next;

    always_comb
    begin
        out_data_next                                = '0;
        out_data_next[SPEED_WIDTH-1:0]               = current_next;
        out_data_next[2*SPEED_WIDTH-1:SPEED_WIDTH]   = target_next;
        out_data_next[B_DRV]                         = enable_next;
        out_data_next[B_RUN]                         = run_next;
        out_data_next[B_AT]                          = at_target;
        out_data_next[B_FLT]                         = fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/bsrc_checker.sv
`timescale 1ns / 1ps

`include "button_speed_ramp_controller_assert.svh"

module bsrc_checker
    import bsrc_pkg::*;
#(
    parameter int SPEED_WIDTH = 11
)
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [((2*SPEED_WIDTH+4+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int B_DRV = 2*SPEED_WIDTH;
    localparam int B_RUN = 2*SPEED_WIDTH + 1;
    localparam int B_AT  = 2*SPEED_WIDTH + 2;
    localparam int B_FLT = 2*SPEED_WIDTH + 3;

    logic [SPEED_WIDTH-1:0] speed;
    logic [SPEED_WIDTH-1:0] target;
    logic                   goal_hit;

    assign speed    = m_axis_tdata[SPEED_WIDTH-1:0];
    assign target   = m_axis_tdata[2*SPEED_WIDTH-1:SPEED_WIDTH];
    assign goal_hit = m_axis_tdata[B_RUN] ? (speed == target) : (speed == '0);

    // a stalled result holds
    `BSRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    // a latched fault never clears
    `BSRC_ASSERT_NEXT(a_fault_sticky, m_axis_tvalid && m_axis_tdata[B_FLT], m_axis_tdata[B_FLT], "fault latch cleared")
    // a faulted block keeps the driver off
    `BSRC_ASSERT(a_fault_drv_off, m_axis_tvalid && m_axis_tdata[B_FLT] |-> !m_axis_tdata[B_DRV], "driver on while faulted")
    // at_target agrees with speed, target and run flag
    `BSRC_ASSERT(a_at_target, m_axis_tvalid |-> (m_axis_tdata[B_AT] == goal_hit), "at_target inconsistent")

endmodule

bind button_speed_ramp_controller bsrc_checker #(.SPEED_WIDTH(SPEED_WIDTH)) u_bsrc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
